/* hw/rtl/skct_pkg.sv */
// Shared types and constants for the sorted key count table.
// No dependencies; imported by every other file of the block.
`default_nettype none

package skct_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 16;
    localparam int COUNT_BITS  = 16;

    // fixed field widths of the stream words
    localparam int POS_BITS    = 7;
    localparam int USED_BITS   = 8;
    localparam int STATUS_BITS = 3;

    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);

    // result select tree: first level groups, TABLE_DEPTH must be a multiple
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = TABLE_DEPTH / GROUP_SIZE;
    localparam int LEAF_BITS   = IDX_BITS + KEY_BITS + COUNT_BITS;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NEW    = 3'd0,
        ST_INCR   = 3'd1,
        ST_DROP   = 3'd2,
        ST_RD_OK  = 3'd3,
        ST_RD_BAD = 3'd4
    } t_status;

    // request broadcast to every cell
    typedef struct packed {
        logic                  wr;     // insert accepted this cycle
        logic                  rd;     // request is a read
        logic [KEY_BITS-1:0]   key;
        logic [FILL_BITS-1:0]  idx;    // read index, zero extended
        logic [FILL_BITS-1:0]  fill;
        logic                  hit;    // some held key equals the request key
        logic                  full;
    } t_cell_op;

endpackage

`default_nettype wire

/* hw/rtl/skct_cell.sv */
// One table slot: holds a key and its count, shifts up from its left neighbor.
// Depends on skct_pkg.
`default_nettype none

module skct_cell
    import skct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_op              i_op,
    input  wire logic [FILL_BITS-1:0]  i_index,
    input  wire logic [KEY_BITS-1:0]   i_prev_key,
    input  wire logic [COUNT_BITS-1:0] i_prev_count,
    input  wire logic                  i_prev_ge,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [COUNT_BITS-1:0]      o_count,
    output logic                       o_ge,
    output logic                       o_eq,
    output logic                       o_sel,
    output logic [KEY_BITS-1:0]        o_rpt_key,
    output logic [COUNT_BITS-1:0]      o_rpt_count
);

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic                  held;
    logic                  ins_here;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign held    = (i_index < i_op.fill);
    assign o_ge    = held && (i_op.key <= r_key);
    assign o_eq    = held && (i_op.key == r_key);
    // keys are sorted, so the first slot at or above the key has a left
    // neighbor below it; an empty table end takes the key at the fill slot
    assign ins_here = !i_prev_ge && (o_ge || (i_index == i_op.fill));
    assign cnt_inc  = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;

    always_comb begin
        if (i_op.rd) begin
            o_sel       = held && (i_index == i_op.idx);
            o_rpt_key   = r_key;
            o_rpt_count = r_count;
        end else if (i_op.hit) begin
            o_sel       = o_eq;
            o_rpt_key   = i_op.key;
            o_rpt_count = cnt_inc;
        end else begin
            o_sel       = !i_op.full && ins_here;
            o_rpt_key   = i_op.key;
            o_rpt_count = {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            if (i_op.hit) begin
                if (o_eq) begin
                    r_count <= cnt_inc;
                end
            end else if (!i_op.full) begin
                if (i_prev_ge) begin
                    r_key   <= i_prev_key;
                    r_count <= i_prev_count;
                end else if (ins_here) begin
                    r_key   <= i_op.key;
                    r_count <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    assign o_key   = r_key;
    assign o_count = r_count;

endmodule

`default_nettype wire

/* hw/rtl/skct_select.sv */
// Two-level registered AND-OR tree picking the one selected slot's report.
// Depends on skct_pkg.
`default_nettype none

module skct_select
    import skct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic [TABLE_DEPTH-1:0] i_sel,
    input  wire logic [LEAF_BITS-1:0]  i_leaf [TABLE_DEPTH],
    output logic [LEAF_BITS-1:0]       o_leaf
);

    logic [LEAF_BITS-1:0] n_grp [NUM_GROUPS];
    logic [LEAF_BITS-1:0] r_grp [NUM_GROUPS];
    logic [LEAF_BITS-1:0] n_out;
    logic [LEAF_BITS-1:0] r_out;

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                n_grp[g] = n_grp[g] |
                    (i_leaf[g*GROUP_SIZE + j] & {LEAF_BITS{i_sel[g*GROUP_SIZE + j]}});
            end
        end
    end

    // no slot selected leaves all zeros
    always_comb begin
        n_out = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_out = n_out | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
            r_out <= n_out;
        end
    end

    assign o_leaf = r_out;

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_count_table_core.sv */
// Sorted key count table: a row of slot cells plus a registered result select.
// Depends on skct_pkg, skct_cell, skct_select.
//
// Usage:
//   Slave side takes one request word per handshake. tuser carries req_type
//   (0 insert key, 1 read entry). tdata carries key and read_index.
//   Master side returns one result word per request, in request order:
//   tdata carries position, entry_key, entry_count, used_entries; tuser
//   carries status.
//   All slots compare against the new key at once and shift up by one in the
//   same cycle, so the table is updated at the accepting edge and a request
//   can be taken every cycle while the master side does not stall: throughput one word per cycle.
//   A result reaches tvalid on the master side through the two register
//   levels of the result select tree.
//   Reset empties the table at once (fill count to zero, no clearing pass);
//   slot contents are only seen below the fill count.
//   While the master side stalls, the whole pipe holds and s_tready is low.
`default_nettype none

module sorted_key_count_table_core
    import skct_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [23:0]  i_s_tdata,   // key[15:0], read_index[22:16], zero[23]
    input  wire logic [0:0]   i_s_tuser,   // req_type[0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [47:0]       o_m_tdata,   // position[6:0], entry_key[22:7],
                                           // entry_count[38:23], used_entries[46:39],
                                           // zero[47]
    output logic [2:0]        o_m_tuser    // status[2:0]
);

    logic                  accept;
    logic                  advance;
    logic                  req_rd;
    logic [KEY_BITS-1:0]   req_key;
    logic [POS_BITS-1:0]   req_idx;

    logic [FILL_BITS-1:0]  r_fill;
    logic [FILL_BITS-1:0]  n_fill;
    t_cell_op              op;
    t_status               n_status;

    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] ge_vec;
    logic [TABLE_DEPTH-1:0] sel_vec;
    logic [KEY_BITS-1:0]    cell_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  cell_count [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    rpt_key    [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  rpt_count  [TABLE_DEPTH];
    logic [LEAF_BITS-1:0]   leaf       [TABLE_DEPTH];
    logic [LEAF_BITS-1:0]   tree_leaf;

    logic                  r_va;
    logic                  r_vb;
    t_status               r_a_status;
    t_status               r_b_status;
    logic [KEY_BITS-1:0]   r_a_key;
    logic [KEY_BITS-1:0]   r_b_key;
    logic [POS_BITS-1:0]   r_a_idx;
    logic [POS_BITS-1:0]   r_b_idx;
    logic [USED_BITS-1:0]  r_a_used;
    logic [USED_BITS-1:0]  r_b_used;

    logic [IDX_BITS-1:0]   tree_idx;
    logic [KEY_BITS-1:0]   tree_key;
    logic [COUNT_BITS-1:0] tree_count;
    logic [POS_BITS-1:0]   out_pos;
    logic [KEY_BITS-1:0]   out_key;

    assign advance    = !r_vb || i_m_tready;
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && advance;

    assign req_rd  = (i_s_tuser[0] == REQ_READ);
    assign req_key = i_s_tdata[KEY_BITS-1:0];
    assign req_idx = i_s_tdata[KEY_BITS +: POS_BITS];

    always_comb begin
        op.wr   = accept && !req_rd;
        op.rd   = req_rd;
        op.key  = req_key;
        op.idx  = FILL_BITS'(req_idx);
        op.fill = r_fill;
        op.hit  = |eq_vec;
        op.full = (r_fill == FILL_BITS'(TABLE_DEPTH));
    end

    always_comb begin
        n_fill = r_fill;
        if (req_rd) begin
            n_status = (op.idx < r_fill) ? ST_RD_OK : ST_RD_BAD;
        end else if (op.hit) begin
            n_status = ST_INCR;
        end else if (op.full) begin
            n_status = ST_DROP;
        end else begin
            n_status = ST_NEW;
            n_fill   = r_fill + 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0]   prev_key;
            logic [COUNT_BITS-1:0] prev_count;
            logic                  prev_ge;

            if (g == 0) begin : g_first
                assign prev_key   = '0;
                assign prev_count = '0;
                assign prev_ge    = 1'b0;
            end else begin : g_rest
                assign prev_key   = cell_key[g-1];
                assign prev_count = cell_count[g-1];
                assign prev_ge    = ge_vec[g-1];
            end

            skct_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (op),
                .i_index      (FILL_BITS'(g)),
                .i_prev_key   (prev_key),
                .i_prev_count (prev_count),
                .i_prev_ge    (prev_ge),
                .o_key        (cell_key[g]),
                .o_count      (cell_count[g]),
                .o_ge         (ge_vec[g]),
                .o_eq         (eq_vec[g]),
                .o_sel        (sel_vec[g]),
                .o_rpt_key    (rpt_key[g]),
                .o_rpt_count  (rpt_count[g])
            );

            assign leaf[g] = {IDX_BITS'(g), rpt_key[g], rpt_count[g]};
        end
    endgenerate

    skct_select u_select (
        .i_clk  (i_clk),
        .i_load (advance),
        .i_sel  (sel_vec),
        .i_leaf (leaf),
        .o_leaf (tree_leaf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
            end
            if (advance) begin
                r_va <= accept;
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_status <= n_status;
            r_a_key    <= req_key;
            r_a_idx    <= req_idx;
            r_a_used   <= USED_BITS'(n_fill);
            r_b_status <= r_a_status;
            r_b_key    <= r_a_key;
            r_b_idx    <= r_a_idx;
            r_b_used   <= r_a_used;
        end
    end

    assign {tree_idx, tree_key, tree_count} = tree_leaf;

    // no slot is selected on a drop or a bad read, so the tree reads zero
    always_comb begin
        out_pos = POS_BITS'(tree_idx);
        out_key = tree_key;
        if (r_b_status == ST_RD_BAD) begin
            out_pos = r_b_idx;
        end else if (r_b_status == ST_DROP) begin
            out_pos = '0;
            out_key = r_b_key;
        end
    end

    assign o_m_tvalid = r_vb;
    assign o_m_tdata  = {1'b0, r_b_used, tree_count, out_key, out_pos};
    assign o_m_tuser  = r_b_status;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_eq_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(eq_vec))
        else $error("key held in more than one slot");

    a_sel_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> $onehot0(sel_vec))
        else $error("more than one slot selected for report");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (n_status == ST_NEW)) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("new entry did not raise fill count");

    a_fill_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_fill))
        else $error("fill count moved without a request");
`endif

endmodule

`default_nettype wire
